[rtl/decimal_text_to_uint64_with_suffix_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the decimal text parser
// Concurrent checks on clk with the asynchronous reset arst_n; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef DECIMAL_TEXT_TO_UINT64_WITH_SUFFIX_MACROS_SVH
`define DECIMAL_TEXT_TO_UINT64_WITH_SUFFIX_MACROS_SVH
`ifndef SYNTHESIS
`define DTU_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define DTU_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define DTU_ASSERT(label, prop, msg)
`define DTU_NEVER(label, cond, msg)
`endif
`endif

[rtl/dtu_pkg.sv]
// ----------------------------------------------------------------------------
// dtu_pkg
// Types, codes and helpers shared by the decimal text parser modules.
// ----------------------------------------------------------------------------
package dtu_pkg;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_NOT_NUMBER = 2'd1,
		ST_BAD_SUFFIX = 2'd2,
		ST_RANGE      = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		PH_SKIP   = 3'b001,
		PH_DIGITS = 3'b010,
		PH_SUFFIX = 3'b100
	} phase_t;

	// Configuration register indexes.
	localparam logic CFG_MIN_VALUE = 1'b0;
	localparam logic CFG_MAX_VALUE = 1'b1;

	// Character codes.
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_LOW_K = 8'h6B;
	localparam logic [7:0] CH_UP_K  = 8'h4B;
	localparam logic [7:0] CH_UP_M  = 8'h4D;
	localparam logic [7:0] CH_UP_G  = 8'h47;
	localparam logic [7:0] CH_UP_B  = 8'h42;
	localparam logic [7:0] CH_LOW_I = 8'h69;

	// Largest accumulator that can still take any further digit without overflow.
	localparam logic [63:0] ACC_LIMIT = (64'hFFFF_FFFF_FFFF_FFFF - 64'd9) / 64'd10;

	// Decimal factors are applied as repeated multiplies by 1000, binary ones
	// as a left shift by ten bits per step.
	typedef struct packed {
		logic       hit;
		logic [1:0] dec_steps;
		logic [1:0] bin_steps;
	} scale_t;

	typedef struct packed {
		logic [63:0] value;
		status_t     status;
		logic [1:0]  dec_steps;
		logic [1:0]  bin_steps;
	} job_t;

	function automatic scale_t suffix_match(input logic [23:0] chars, input logic [2:0] len);
		scale_t     r;
		logic [1:0] dec_n;
		logic [1:0] bin_n;
		logic [7:0] c0;
		logic [7:0] c1;
		logic [7:0] c2;
		r  = '0;
		c0 = chars[7:0];
		c1 = chars[15:8];
		c2 = chars[23:16];
		dec_n = (c0 == CH_LOW_K) ? 2'd1 : (c0 == CH_UP_M) ? 2'd2 : (c0 == CH_UP_G) ? 2'd3 : 2'd0;
		bin_n = (c0 == CH_UP_K) ? 2'd1 : (c0 == CH_UP_M) ? 2'd2 : (c0 == CH_UP_G) ? 2'd3 : 2'd0;
		case (len)
			3'd1: begin
				if (dec_n != 2'd0) begin
					r.hit = 1'b1;
					r.dec_steps = dec_n;
				end
			end
			3'd2: begin
				if (c1 == CH_UP_B && dec_n != 2'd0) begin
					r.hit = 1'b1;
					r.dec_steps = dec_n;
				end else if (c1 == CH_LOW_I && bin_n != 2'd0) begin
					r.hit = 1'b1;
					r.bin_steps = bin_n;
				end
			end
			3'd3: begin
				if (c1 == CH_LOW_I && c2 == CH_UP_B && bin_n != 2'd0) begin
					r.hit = 1'b1;
					r.bin_steps = bin_n;
				end
			end
			default: r = '0;
		endcase
		return r;
	endfunction

	// v * 1000 as (v << 10) - (v << 4) - (v << 3), kept wide for the overflow check.
	function automatic logic [73:0] mul1000(input logic [63:0] v);
		logic [73:0] w;
		w = {10'd0, v};
		return (w << 10) - (w << 4) - (w << 3);
	endfunction

endpackage

[rtl/dtu_front.sv]
// ----------------------------------------------------------------------------
// dtu_front
// Takes one character per transfer, tracks the parse phase, builds the value
// from the digits and collects the suffix. A NUL hands a job to the queue.
// ----------------------------------------------------------------------------
`include "decimal_text_to_uint64_with_suffix_macros.svh"

module dtu_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic [7:0]    ch,
	input  logic          queue_full,
	output logic          push,
	output dtu_pkg::job_t job
);
	import dtu_pkg::*;

	logic [63:0] acc_q, acc_d;
	phase_t      phase_q, phase_d;
	status_t     err_q, err_d;
	logic [23:0] sfx_q, sfx_d;
	logic [2:0]  slen_q, slen_d;

	logic        accept;
	logic        is_digit;
	logic        is_blank;
	logic [3:0]  digit_val;
	logic [63:0] acc_x10;
	logic        append;
	scale_t      scale;

	assign in_stall  = queue_full;
	assign accept    = in_valid && !in_stall;
	assign is_digit  = (ch >= CH_ZERO) && (ch <= CH_NINE);
	assign is_blank  = (ch == CH_SPACE) || (ch == CH_TAB);
	assign digit_val = 4'(ch - CH_ZERO);
	assign acc_x10   = (acc_q << 3) + (acc_q << 1) + {60'd0, digit_val};
	assign scale     = suffix_match(sfx_q, slen_q);

	// Job for the back end, built from the state that the NUL closes.
	always_comb begin
		job.value     = acc_q;
		job.status    = ST_OK;
		job.dec_steps = 2'd0;
		job.bin_steps = 2'd0;
		if (err_q != ST_OK) begin
			job.status = err_q;
		end else if (phase_q != PH_DIGITS && phase_q != PH_SUFFIX) begin
			job.status = ST_NOT_NUMBER;
		end else if (slen_q != 3'd0) begin
			if (!scale.hit) begin
				job.status = ST_BAD_SUFFIX;
			end else begin
				job.dec_steps = scale.dec_steps;
				job.bin_steps = scale.bin_steps;
			end
		end
	end

	always_comb begin
		acc_d   = acc_q;
		phase_d = phase_q;
		err_d   = err_q;
		sfx_d   = sfx_q;
		slen_d  = slen_q;
		append  = 1'b0;
		push    = 1'b0;
		if (accept) begin
			if (ch == CH_NUL) begin
				push    = 1'b1;
				acc_d   = '0;
				phase_d = PH_SKIP;
				err_d   = ST_OK;
				sfx_d   = '0;
				slen_d  = '0;
			end else if (err_q == ST_OK) begin
				case (phase_q)
					PH_DIGITS: begin
						if (is_digit) begin
							if (acc_q > ACC_LIMIT) begin
								err_d = ST_RANGE;
							end else begin
								acc_d = acc_x10;
							end
						end else begin
							// The first non-digit opens the suffix and belongs to it.
							phase_d = PH_SUFFIX;
							append  = 1'b1;
						end
					end
					PH_SUFFIX: append = 1'b1;
					default: begin
						if (!is_blank) begin
							if (is_digit) begin
								acc_d   = {60'd0, digit_val};
								phase_d = PH_DIGITS;
							end else begin
								err_d = ST_NOT_NUMBER;
							end
						end
					end
				endcase
			end
			if (append) begin
				case (slen_q)
					3'd0: begin
						sfx_d[7:0] = ch;
						slen_d = 3'd1;
					end
					3'd1: begin
						sfx_d[15:8] = ch;
						slen_d = 3'd2;
					end
					3'd2: begin
						sfx_d[23:16] = ch;
						slen_d = 3'd3;
					end
					default: slen_d = 3'd4;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			phase_q <= PH_SKIP;
			err_q   <= ST_OK;
			sfx_q   <= '0;
			slen_q  <= '0;
		end else begin
			acc_q   <= acc_d;
			phase_q <= phase_d;
			err_q   <= err_d;
			sfx_q   <= sfx_d;
			slen_q  <= slen_d;
		end
	end

	`DTU_ASSERT(a_nul_clears, push |=> (phase_q == PH_SKIP && err_q == ST_OK && slen_q == 3'd0), "text state not cleared after NUL")
	`DTU_NEVER(a_slen_range, slen_q > 3'd4, "suffix length beyond saturation")

endmodule

[rtl/dtu_queue.sv]
// ----------------------------------------------------------------------------
// dtu_queue
// Small job queue between the front and back ends, first in first out.
// ----------------------------------------------------------------------------
`include "decimal_text_to_uint64_with_suffix_macros.svh"

module dtu_queue #(
	parameter int DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  dtu_pkg::job_t wr_job,
	input  logic          pop,
	output dtu_pkg::job_t rd_job,
	output logic          full,
	output logic          not_empty
);
	import dtu_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             slots_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign rd_job    = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`DTU_ASSERT(a_no_overflow, push |-> !full, "push into a full queue")
	`DTU_ASSERT(a_no_underflow, pop |-> not_empty, "pop from an empty queue")

endmodule

[rtl/dtu_back.sv]
// ----------------------------------------------------------------------------
// dtu_back
// Scales each job by its suffix factor with overflow checks, applies the
// min/max window and holds the result in the output register.
// ----------------------------------------------------------------------------
`include "decimal_text_to_uint64_with_suffix_macros.svh"

module dtu_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          job_avail,
	input  dtu_pkg::job_t job,
	output logic          pop,
	input  logic [63:0]   min_value,
	input  logic [63:0]   max_value,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [63:0]   number,
	output logic [1:0]    status
);
	import dtu_pkg::*;

	logic  advance;
	job_t  job_s1, job_s2, job_s3, job_s4;
	logic  vld_s1, vld_s2, vld_s3, vld_s4;
	job_t  shifted;
	logic  vld_q;
	logic [63:0] number_q;
	status_t     status_q;
	status_t     final_status;

	// The whole pipeline moves together whenever the output register can load.
	assign advance = !vld_q || !out_stall;
	assign pop     = advance && job_avail;

	// Binary factors: shift by 10, 20 or 30 bits, overflow if bits fall off.
	always_comb begin
		shifted = job;
		shifted.bin_steps = 2'd0;
		if (job.status == ST_OK) begin
			case (job.bin_steps)
				2'd1: begin
					shifted.value = job.value << 10;
					if (|job.value[63:54]) shifted.status = ST_RANGE;
				end
				2'd2: begin
					shifted.value = job.value << 20;
					if (|job.value[63:44]) shifted.status = ST_RANGE;
				end
				2'd3: begin
					shifted.value = job.value << 30;
					if (|job.value[63:34]) shifted.status = ST_RANGE;
				end
				default: shifted.value = job.value;
			endcase
		end
	end

	// One multiply by 1000 when the job still needs more than `step` of them.
	function automatic job_t dec_step(input job_t j, input logic [1:0] step);
		job_t        r;
		logic [73:0] p;
		r = j;
		p = mul1000(j.value);
		if (j.status == ST_OK && j.dec_steps > step) begin
			r.value = p[63:0];
			if (|p[73:64]) r.status = ST_RANGE;
		end
		return r;
	endfunction

	always_comb begin
		final_status = job_s4.status;
		if (job_s4.status == ST_OK &&
		    (job_s4.value < min_value || job_s4.value > max_value)) begin
			final_status = ST_RANGE;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			job_s1 <= shifted;
			job_s2 <= dec_step(job_s1, 2'd0);
			job_s3 <= dec_step(job_s2, 2'd1);
			job_s4 <= dec_step(job_s3, 2'd2);
			number_q <= (final_status == ST_OK) ? job_s4.value : '0;
			status_q <= final_status;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_q  <= 1'b0;
		end else if (advance) begin
			vld_s1 <= job_avail;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_q  <= vld_s4;
		end
	end

	assign out_valid = vld_q;
	assign number    = number_q;
	assign status    = status_q;

	`DTU_ASSERT(a_zero_on_error, out_valid |-> (status_q == ST_OK || number_q == 64'd0), "nonzero number with error status")

endmodule

[rtl/decimal_text_to_uint64_with_suffix.sv]
// ----------------------------------------------------------------------------
// decimal_text_to_uint64_with_suffix
// Parses decimal text with an optional k/M/G (x1000 steps) or Ki/Mi/Gi
// (x1024 steps) suffix, optionally followed by B, into a 64-bit value.
// Input channel: one character per transfer on ch; a NUL ends the text.
// Leading blanks are skipped. Output channel: one result per text, number
// and status (0 ok, 1 not a number, 2 bad suffix, 3 range or overflow).
// Input takes one character per cycle while in_stall is low. A NUL transfer
// puts its job in the job queue; from there it passes four stages
// of scaling (binary shift, then up to three multiplies by 1000), then the
// range check into the output register.
// When the output is stalled the pipeline holds; the front keeps taking
// characters until the job queue fills, then stalls the input.
// Reset clears the text state, the queue and the pipeline; min_value
// resets to 0 and max_value to all ones. Write them with cfg_we only while
// the block is idle.
// ----------------------------------------------------------------------------
module decimal_text_to_uint64_with_suffix #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  ch,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] number,
	output logic [1:0]  status,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [63:0] cfg_wdata
);
	import dtu_pkg::*;

	logic [63:0] min_q;
	logic [63:0] max_q;
	logic        push;
	logic        pop;
	logic        queue_full;
	logic        queue_avail;
	job_t        front_job;
	job_t        head_job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= '0;
			max_q <= '1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MIN_VALUE: min_q <= cfg_wdata;
				CFG_MAX_VALUE: max_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	dtu_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.ch         (ch),
		.queue_full (queue_full),
		.push       (push),
		.job        (front_job)
	);

	dtu_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_job    (front_job),
		.pop       (pop),
		.rd_job    (head_job),
		.full      (queue_full),
		.not_empty (queue_avail)
	);

	dtu_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_avail (queue_avail),
		.job       (head_job),
		.pop       (pop),
		.min_value (min_q),
		.max_value (max_q),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.number    (number),
		.status    (status)
	);

endmodule

[tb/dtu_parse_monitor.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dtu_parse_monitor
// Watches both channels and the register port of the decimal text parser.
// It keeps its own copy of the parse state and the bounds, works out the
// result of every text at its NUL, and compares each result transfer with
// the oldest one still due.
// ----------------------------------------------------------------------------
module dtu_parse_monitor (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [7:0]  ch,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [63:0] number,
	input  logic [1:0]  status,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [63:0] cfg_wdata,
	output int          mismatches,
	output int          results_due
);
	import dtu_pkg::*;

	typedef struct packed {
		logic [63:0] value;
		status_t     code;
	} text_result_t;

	localparam logic [63:0] DIGIT_GUARD = 64'd1844674407370955160;

	text_result_t due_q[$];
	logic [63:0]  lo_bound;
	logic [63:0]  hi_bound;
	logic [63:0]  acc;
	phase_t       phase;
	status_t      first_err;
	logic [23:0]  sfx;
	logic [2:0]   sfx_len;
	int           errs;

	// Scale factor of a stored suffix, zero when the suffix is not a known unit.
	function automatic logic [63:0] unit_factor(input logic [23:0] s, input logic [2:0] n);
		logic [7:0]  c0;
		logic [7:0]  c1;
		logic [7:0]  c2;
		logic [63:0] si;
		logic [63:0] iec;
		c0 = s[7:0];
		c1 = s[15:8];
		c2 = s[23:16];
		si = (c0 == CH_LOW_K) ? 64'd1000 :
		     (c0 == CH_UP_M)  ? 64'd1000000 :
		     (c0 == CH_UP_G)  ? 64'd1000000000 : 64'd0;
		iec = (c0 == CH_UP_K) ? 64'd1 << 10 :
		      (c0 == CH_UP_M) ? 64'd1 << 20 :
		      (c0 == CH_UP_G) ? 64'd1 << 30 : 64'd0;
		case (n)
			3'd1: return si;
			3'd2: begin
				if (c1 == CH_UP_B)
					return si;
				if (c1 == CH_LOW_I)
					return iec;
				return 64'd0;
			end
			3'd3: return (c1 == CH_LOW_I && c2 == CH_UP_B) ? iec : 64'd0;
			default: return 64'd0;
		endcase
	endfunction

	task automatic clear_text();
		acc = '0;
		phase = PH_SKIP;
		first_err = ST_OK;
		sfx = '0;
		sfx_len = '0;
	endtask

	task automatic add_suffix_char(input logic [7:0] c);
		if (sfx_len < 3'd3) begin
			sfx[8*sfx_len +: 8] = c;
			sfx_len = sfx_len + 3'd1;
		end else begin
			sfx_len = 3'd4;
		end
	endtask

	function automatic text_result_t text_outcome();
		text_result_t r;
		logic [63:0]  f;
		logic [127:0] prod;
		r.value = '0;
		r.code = ST_OK;
		prod = {64'd0, acc};
		if (first_err != ST_OK) begin
			r.code = first_err;
		end else if (phase != PH_DIGITS && phase != PH_SUFFIX) begin
			r.code = ST_NOT_NUMBER;
		end else begin
			if (sfx_len != 3'd0) begin
				f = unit_factor(sfx, sfx_len);
				if (f == 64'd0)
					r.code = ST_BAD_SUFFIX;
				else
					prod = {64'd0, acc} * {64'd0, f};
			end
			if (r.code == ST_OK) begin
				if (prod[127:64] != 64'd0 || prod[63:0] < lo_bound || prod[63:0] > hi_bound)
					r.code = ST_RANGE;
				else
					r.value = prod[63:0];
			end
		end
		return r;
	endfunction

	task automatic take_char(input logic [7:0] c);
		logic is_digit;
		is_digit = (c >= CH_ZERO && c <= CH_NINE);
		if (c == CH_NUL) begin
			due_q.push_back(text_outcome());
			clear_text();
		end else if (first_err == ST_OK) begin
			case (phase)
				PH_DIGITS: begin
					if (is_digit) begin
						if (acc > DIGIT_GUARD)
							first_err = ST_RANGE;
						else
							acc = acc * 64'd10 + {56'd0, c - CH_ZERO};
					end else begin
						phase = PH_SUFFIX;
						add_suffix_char(c);
					end
				end
				PH_SUFFIX: add_suffix_char(c);
				default: begin
					if (c != CH_SPACE && c != CH_TAB) begin
						if (!is_digit) begin
							first_err = ST_NOT_NUMBER;
						end else begin
							acc = {56'd0, c - CH_ZERO};
							phase = PH_DIGITS;
						end
					end
				end
			endcase
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		text_result_t want;
		if (!arst_n) begin
			lo_bound = '0;
			hi_bound = '1;
			clear_text();
			due_q.delete();
			errs = 0;
			mismatches <= 0;
			results_due <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_MIN_VALUE: lo_bound = cfg_wdata;
					CFG_MAX_VALUE: hi_bound = cfg_wdata;
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (due_q.size() == 0) begin
					errs++;
					$display("%0t: result with none due: expected none, actual number=%h status=%0d",
						$time, number, status);
				end else begin
					want = due_q.pop_front();
					if (number !== want.value) begin
						errs++;
						$display("%0t: number mismatch: expected %h, actual %h",
							$time, want.value, number);
					end
					if (status !== want.code) begin
						errs++;
						$display("%0t: status mismatch: expected %0d, actual %0d",
							$time, want.code, status);
					end
				end
			end
			if (in_valid && !in_stall)
				take_char(ch);
			mismatches <= errs;
			results_due <= due_q.size();
		end
	end

endmodule

[tb/tb_decimal_text_to_uint64_with_suffix.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_decimal_text_to_uint64_with_suffix
// Feeds the decimal text parser with directed and random texts, one
// character per transfer, under several bound settings, with random idling
// on both channels and one long output hold-off. Checking is done by the
// monitor instance; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_decimal_text_to_uint64_with_suffix;
	import dtu_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  ch;
	logic        out_valid;
	logic        out_stall;
	logic [63:0] number;
	logic [1:0]  status;
	logic        cfg_we;
	logic        cfg_index;
	logic [63:0] cfg_wdata;
	int          mismatches;
	int          results_due;

	logic [7:0] text_buf[$];
	int         chars_sent;
	bit         sender_gaps;
	bit         receiver_gaps;
	int         hold_asks;
	int         holds_done;
	string      unit_names[12] = '{"k", "kB", "M", "MB", "G", "GB",
	                               "Ki", "KiB", "Mi", "MiB", "Gi", "GiB"};

	decimal_text_to_uint64_with_suffix dut (.*);

	dtu_parse_monitor mon (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	// Output side: random stall bursts, plus a long hold-off on request.
	initial begin
		holds_done = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_asks != holds_done) begin
				out_stall <= 1'b1;
				repeat (400) @(posedge clk);
				holds_done++;
				out_stall <= 1'b0;
			end else if (receiver_gaps && $urandom_range(0, 7) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 17)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	task automatic send_char(input logic [7:0] c);
		if (sender_gaps && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			ch <= 8'($urandom);
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		in_valid <= 1'b1;
		ch <= c;
		do @(posedge clk); while (in_stall);
		chars_sent++;
	endtask

	task automatic send_text();
		foreach (text_buf[i])
			send_char(text_buf[i]);
	endtask

	task automatic push_str(input string s);
		for (int i = 0; i < s.len(); i++)
			text_buf.push_back(s[i]);
	endtask

	task automatic push_digit();
		text_buf.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
	endtask

	function automatic logic [7:0] suffix_noise();
		string pool;
		pool = "kMGKiB 9x";
		if ($urandom_range(0, 2) == 0)
			return 8'($urandom_range(1, 255));
		return pool[$urandom_range(0, pool.len() - 1)];
	endfunction

	// Mostly well-formed numbers with random content; the rest are broken.
	task automatic make_text();
		int         kind;
		logic [7:0] b;
		text_buf.delete();
		kind = $urandom_range(0, 99);
		if (kind < 85) begin
			repeat ($urandom_range(0, 2))
				text_buf.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
			case ($urandom_range(0, 9))
				0: push_str("18446744073709551615");
				1: begin
					push_str("1844674407370955161");
					push_digit();
				end
				2: repeat ($urandom_range(20, 22)) push_digit();
				3: repeat ($urandom_range(7, 19)) push_digit();
				default: repeat ($urandom_range(1, 6)) push_digit();
			endcase
			if (kind < 70) begin
				if ($urandom_range(0, 6) != 0)
					push_str(unit_names[$urandom_range(0, 11)]);
			end else begin
				repeat ($urandom_range(1, 5)) text_buf.push_back(suffix_noise());
			end
		end else if (kind < 93) begin
			do b = 8'($urandom_range(1, 255));
			while (b == CH_SPACE || b == CH_TAB || (b >= CH_ZERO && b <= CH_NINE));
			text_buf.push_back(b);
			repeat ($urandom_range(0, 3)) text_buf.push_back(8'($urandom_range(1, 255)));
		end else begin
			repeat ($urandom_range(0, 6)) text_buf.push_back(8'($urandom_range(1, 255)));
		end
		text_buf.push_back(CH_NUL);
	endtask

	task automatic send_random(input int target);
		int start;
		start = chars_sent;
		while (chars_sent - start < target) begin
			make_text();
			send_text();
		end
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		do @(posedge clk); while (results_due != 0);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_bounds(input logic [63:0] lo, input logic [63:0] hi);
		cfg_we <= 1'b1;
		cfg_index <= CFG_MIN_VALUE;
		cfg_wdata <= lo;
		@(posedge clk);
		cfg_index <= CFG_MAX_VALUE;
		cfg_wdata <= hi;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Zero, empty text, leading blanks before a number with a unit, a high character first,
	// a bad unit, an over-long unit and a binary unit.
	task automatic run_directed();
		text_buf.delete();
		push_str("0");
		text_buf.push_back(CH_NUL);
		text_buf.push_back(CH_NUL);
		push_str(" \t42kB");
		text_buf.push_back(CH_NUL);
		text_buf.push_back(8'hFF);
		text_buf.push_back(CH_NUL);
		push_str("3x");
		text_buf.push_back(CH_NUL);
		push_str("1KiBs");
		text_buf.push_back(CH_NUL);
		push_str("2Gi");
		text_buf.push_back(CH_NUL);
		send_text();
	endtask

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		ch <= CH_NUL;
		cfg_we <= 1'b0;
		cfg_index <= CFG_MIN_VALUE;
		cfg_wdata <= '0;
		sender_gaps = 1'b1;
		receiver_gaps = 1'b1;
		hold_asks = 0;
		chars_sent = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		send_random(150);
		wait_idle();

		write_bounds(64'd0, 64'd0);
		send_random(100);
		wait_idle();

		write_bounds('1, '1);
		send_random(100);
		wait_idle();

		// Hold the output long enough that the job queue fills and the
		// input stalls while short texts keep coming.
		write_bounds(64'd1000, 64'd1000000000);
		hold_asks++;
		repeat (12) begin
			text_buf.delete();
			push_digit();
			text_buf.push_back(CH_NUL);
			send_text();
		end
		send_random(120);
		wait_idle();

		write_bounds(64'd0, '1);
		sender_gaps = 1'b0;
		receiver_gaps = 1'b0;
		send_random(130);
		wait_idle();

		if (mismatches == 0 && results_due == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
